@@ rtl/core/rpn_pkg.sv @@
// shared types and constants for the rpn stack evaluator
// token and result payloads, opcode and status codes, controller command bundle
`timescale 1ns / 1ps

package rpn_pkg;

  localparam int DATA_W          = 32;
  localparam int FRAC_W          = 16;
  localparam int PROD_W          = 2 * DATA_W;
  localparam int TRUNC_W         = PROD_W - FRAC_W;
  localparam int DEF_STACK_DEPTH = 64;

  localparam logic [2:0] OPC_PUSH = 3'd0;
  localparam logic [2:0] OPC_ADD  = 3'd1;
  localparam logic [2:0] OPC_SUB  = 3'd2;
  localparam logic [2:0] OPC_MUL  = 3'd3;
  localparam logic [2:0] OPC_DIV  = 3'd4;

  localparam logic [1:0] STATUS_OK       = 2'd0;
  localparam logic [1:0] STATUS_ZERO_DIV = 2'd1;
  localparam logic [1:0] STATUS_UNKNOWN  = 2'd2;

  localparam logic signed [DATA_W-1:0] SAT_MAX = {1'b0, {(DATA_W-1){1'b1}}};
  localparam logic signed [DATA_W-1:0] SAT_MIN = {1'b1, {(DATA_W-1){1'b0}}};

  typedef struct packed {
    logic [2:0]               opcode;
    logic signed [DATA_W-1:0] operand_value;
    logic                     last_token;
  } token_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] answer;
    logic [1:0]               status;
  } result_t;

  typedef enum logic [2:0] {
    ALU_NONE,
    ALU_ADD,
    ALU_SUB,
    ALU_MUL,
    ALU_TRUNC,
    ALU_SAT,
    ALU_DIV
  } alu_op_t;

  typedef struct packed {
    logic       pop;
    logic       ld_b;
    logic       ld_a;
    logic       push_in;
    logic       push_res;
    alu_op_t    alu_op;
    logic       div_start;
    logic       emit;
    logic       emit_err;
    logic [1:0] emit_status;
    logic       clear;
  } cmd_t;

  typedef struct packed {
    logic b_zero;
    logic div_done;
    logic out_busy;
  } stat_t;

endpackage

@@ rtl/core/rpn_div.sv @@
// iterative signed q16.16 divider, two quotient bits per cycle
// depends on rpn_pkg for data widths and saturation limits
`timescale 1ns / 1ps

module rpn_div (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  input  logic signed [rpn_pkg::DATA_W-1:0] dividend,
  input  logic signed [rpn_pkg::DATA_W-1:0] divisor,
  output logic                              done,
  output logic signed [rpn_pkg::DATA_W-1:0] quotient
);

  localparam int DW    = rpn_pkg::DATA_W;
  localparam int NW    = DW + rpn_pkg::FRAC_W;
  localparam int RADIX = 2;
  localparam int STEPS = NW / RADIX;
  localparam int CW    = $clog2(STEPS);

  typedef enum logic [1:0] {
    D_IDLE,
    D_RUN,
    D_FIN
  } dstate_t;

  dstate_t         state;
  logic            neg;
  logic [DW-1:0]   dvsr;
  logic [DW-1:0]   rem;
  logic [NW-1:0]   num;
  logic [CW-1:0]   cnt;
  logic [DW-1:0]   rem_next;
  logic [NW-1:0]   num_next;
  logic [DW-1:0]   abs_a;
  logic [DW-1:0]   abs_b;

  assign abs_a = dividend[DW-1] ? (~dividend + DW'(1)) : dividend;
  assign abs_b = divisor[DW-1] ? (~divisor + DW'(1)) : divisor;

  always_comb begin
    logic [DW:0] r2;
    r2       = '0;
    rem_next = rem;
    num_next = num;
    for (int i = 0; i < RADIX; i++) begin
      r2 = {rem_next, num_next[NW-1]};
      if (r2 >= {1'b0, dvsr}) begin
        rem_next = DW'(r2 - {1'b0, dvsr});
        num_next = {num_next[NW-2:0], 1'b1};
      end else begin
        rem_next = r2[DW-1:0];
        num_next = {num_next[NW-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= D_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        D_IDLE: begin
          if (start) begin
            neg   <= dividend[DW-1] ^ divisor[DW-1];
            dvsr  <= abs_b;
            num   <= {abs_a, {rpn_pkg::FRAC_W{1'b0}}};
            rem   <= '0;
            cnt   <= '0;
            state <= D_RUN;
          end
        end
        D_RUN: begin
          rem <= rem_next;
          num <= num_next;
          cnt <= cnt + CW'(1);
          if (cnt == CW'(STEPS - 1)) begin
            state <= D_FIN;
          end
        end
        D_FIN: begin
          if (!neg) begin
            quotient <= (|num[NW-1:DW-1]) ? rpn_pkg::SAT_MAX : num[DW-1:0];
          end else if (num > NW'({1'b1, {(DW-1){1'b0}}})) begin
            quotient <= rpn_pkg::SAT_MIN;
          end else begin
            quotient <= ~num[DW-1:0] + DW'(1);
          end
          done  <= 1'b1;
          state <= D_IDLE;
        end
        default: state <= D_IDLE;
      endcase
    end
  end

endmodule

@@ rtl/core/rpn_dpath.sv @@
// datapath: operand stack memory, stack pointer, operand and result registers,
// saturating alu, divider and the result output register; uses rpn_pkg and rpn_div
`timescale 1ns / 1ps

module rpn_dpath #(
  parameter int STACK_DEPTH = rpn_pkg::DEF_STACK_DEPTH
) (
  input  logic                              clk,
  input  logic                              rst,
  input  rpn_pkg::cmd_t                     cmd,
  input  logic signed [rpn_pkg::DATA_W-1:0] push_value,
  output rpn_pkg::stat_t                    stat,
  output logic                              result_valid,
  input  logic                              result_ready,
  output rpn_pkg::result_t                  result
);

  localparam int DW  = rpn_pkg::DATA_W;
  localparam int AW  = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int SPW = $clog2(STACK_DEPTH + 1);
  localparam int TW  = rpn_pkg::TRUNC_W;
  localparam int PW  = rpn_pkg::PROD_W;

  logic [DW-1:0]           mem [STACK_DEPTH];
  logic [SPW-1:0]          sp;
  logic [SPW-1:0]          sp_m1;
  logic                    full;
  logic [DW-1:0]           rd_data;
  logic                    pop_ok;
  logic signed [DW-1:0]    pop_val;
  logic signed [DW-1:0]    a_reg;
  logic signed [DW-1:0]    b_reg;
  logic signed [DW-1:0]    res;
  logic signed [PW-1:0]    prod;
  logic signed [TW-1:0]    trunc;
  logic signed [DW:0]      sum;
  logic signed [PW-1:0]    biased;
  logic                    push_en;
  logic [DW-1:0]           wdata;
  logic                    div_done;
  logic signed [DW-1:0]    div_q;

  assign sp_m1   = sp - SPW'(1);
  assign full    = (sp == SPW'(STACK_DEPTH));
  assign pop_val = pop_ok ? rd_data : '0;
  assign push_en = (cmd.push_in || cmd.push_res) && !full;
  assign wdata   = cmd.push_in ? push_value : res;

  assign sum    = (cmd.alu_op == rpn_pkg::ALU_SUB) ? ({a_reg[DW-1], a_reg} - {b_reg[DW-1], b_reg})
                                                   : ({a_reg[DW-1], a_reg} + {b_reg[DW-1], b_reg});
  assign biased = prod + (prod[PW-1] ? PW'((1 << rpn_pkg::FRAC_W) - 1) : PW'(0));

  assign stat.b_zero   = (b_reg == '0);
  assign stat.div_done = div_done;
  assign stat.out_busy = result_valid && !result_ready;

  rpn_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (a_reg),
    .divisor  (b_reg),
    .done     (div_done),
    .quotient (div_q)
  );

  // stack memory with registered read
  always_ff @(posedge clk) begin
    if (push_en) begin
      mem[sp[AW-1:0]] <= wdata;
    end
    if (cmd.pop) begin
      rd_data <= mem[sp_m1[AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sp     <= '0;
      pop_ok <= 1'b0;
    end else begin
      if (cmd.pop) begin
        pop_ok <= (sp != '0);
      end
      priority if (cmd.clear) begin
        sp <= '0;
      end else if (cmd.pop) begin
        if (sp != '0) begin
          sp <= sp_m1;
        end
      end else if (push_en) begin
        sp <= sp + SPW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.ld_b) begin
      b_reg <= pop_val;
    end
    if (cmd.ld_a) begin
      a_reg <= pop_val;
    end
    unique case (cmd.alu_op)
      rpn_pkg::ALU_ADD, rpn_pkg::ALU_SUB: begin
        if (sum[DW] != sum[DW-1]) begin
          res <= sum[DW] ? rpn_pkg::SAT_MIN : rpn_pkg::SAT_MAX;
        end else begin
          res <= sum[DW-1:0];
        end
      end
      rpn_pkg::ALU_MUL:   prod  <= PW'(a_reg) * PW'(b_reg);
      rpn_pkg::ALU_TRUNC: trunc <= biased[PW-1:rpn_pkg::FRAC_W];
      rpn_pkg::ALU_SAT: begin
        if ((&trunc[TW-1:DW-1]) || !(|trunc[TW-1:DW-1])) begin
          res <= trunc[DW-1:0];
        end else begin
          res <= trunc[TW-1] ? rpn_pkg::SAT_MIN : rpn_pkg::SAT_MAX;
        end
      end
      rpn_pkg::ALU_DIV:   res <= div_q;
      rpn_pkg::ALU_NONE:  ;
      default:            ;
    endcase
  end

  // result output register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (cmd.emit) begin
      result_valid  <= 1'b1;
      result.answer <= cmd.emit_err ? '0 : pop_val;
      result.status <= cmd.emit_status;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

endmodule

@@ rtl/core/rpn_ctrl.sv @@
// controller: token sequencing, abort tracking and result hand-off
// drives the rpn_pkg command bundle into the datapath and reads its status
`timescale 1ns / 1ps

module rpn_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           token_valid,
  output logic           token_ready,
  input  logic [2:0]     opcode,
  input  logic           last_token,
  input  rpn_pkg::stat_t stat,
  output rpn_pkg::cmd_t  cmd
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_POPB,
    S_POPA,
    S_EXEC,
    S_MUL2,
    S_MUL3,
    S_DIVW,
    S_PUSH,
    S_FINPOP,
    S_EMIT
  } state_t;

  state_t     state;
  logic [2:0] op;
  logic       last;
  logic       aborted;
  logic       is_err;
  logic [1:0] err_status;
  logic       is_arith;

  assign token_ready = (state == S_IDLE);
  assign is_arith    = (opcode == rpn_pkg::OPC_ADD) || (opcode == rpn_pkg::OPC_SUB) ||
                       (opcode == rpn_pkg::OPC_MUL) || (opcode == rpn_pkg::OPC_DIV);

  always_comb begin
    cmd             = '0;
    cmd.alu_op      = rpn_pkg::ALU_NONE;
    cmd.emit_status = rpn_pkg::STATUS_OK;
    unique case (state)
      S_IDLE: begin
        if (token_valid) begin
          if (aborted) begin
            cmd.clear = last_token;
          end else if (opcode == rpn_pkg::OPC_PUSH) begin
            cmd.push_in = 1'b1;
          end else if (is_arith) begin
            cmd.pop = 1'b1;
          end
        end
      end
      S_POPB: begin
        cmd.ld_b = 1'b1;
        cmd.pop  = 1'b1;
      end
      S_POPA: cmd.ld_a = 1'b1;
      S_EXEC: begin
        if (op == rpn_pkg::OPC_ADD) begin
          cmd.alu_op = rpn_pkg::ALU_ADD;
        end else if (op == rpn_pkg::OPC_SUB) begin
          cmd.alu_op = rpn_pkg::ALU_SUB;
        end else if (op == rpn_pkg::OPC_MUL) begin
          cmd.alu_op = rpn_pkg::ALU_MUL;
        end else begin
          cmd.div_start = !stat.b_zero;
        end
      end
      S_MUL2:   cmd.alu_op = rpn_pkg::ALU_TRUNC;
      S_MUL3:   cmd.alu_op = rpn_pkg::ALU_SAT;
      S_DIVW:   cmd.alu_op = stat.div_done ? rpn_pkg::ALU_DIV : rpn_pkg::ALU_NONE;
      S_PUSH:   cmd.push_res = 1'b1;
      S_FINPOP: cmd.pop = 1'b1;
      S_EMIT: begin
        if (!stat.out_busy) begin
          cmd.emit        = 1'b1;
          cmd.emit_err    = is_err;
          cmd.emit_status = is_err ? err_status : rpn_pkg::STATUS_OK;
          cmd.clear       = last;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      aborted    <= 1'b0;
      is_err     <= 1'b0;
      err_status <= rpn_pkg::STATUS_OK;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (token_valid) begin
            op   <= opcode;
            last <= last_token;
            if (aborted) begin
              if (last_token) begin
                aborted <= 1'b0;
              end
            end else if (opcode == rpn_pkg::OPC_PUSH) begin
              if (last_token) begin
                state <= S_FINPOP;
              end
            end else if (is_arith) begin
              state <= S_POPB;
            end else begin
              is_err     <= 1'b1;
              err_status <= rpn_pkg::STATUS_UNKNOWN;
              state      <= S_EMIT;
            end
          end
        end
        S_POPB: state <= S_POPA;
        S_POPA: state <= S_EXEC;
        S_EXEC: begin
          if (op == rpn_pkg::OPC_MUL) begin
            state <= S_MUL2;
          end else if (op == rpn_pkg::OPC_DIV) begin
            if (stat.b_zero) begin
              is_err     <= 1'b1;
              err_status <= rpn_pkg::STATUS_ZERO_DIV;
              state      <= S_EMIT;
            end else begin
              state <= S_DIVW;
            end
          end else begin
            state <= S_PUSH;
          end
        end
        S_MUL2: state <= S_MUL3;
        S_MUL3: state <= S_PUSH;
        S_DIVW: begin
          if (stat.div_done) begin
            state <= S_PUSH;
          end
        end
        S_PUSH:   state <= last ? S_FINPOP : S_IDLE;
        S_FINPOP: state <= S_EMIT;
        S_EMIT: begin
          if (!stat.out_busy) begin
            if (is_err && !last) begin
              aborted <= 1'b1;
            end
            is_err <= 1'b0;
            state  <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

@@ rtl/core/rpn_stack_evaluator.sv @@
// top level of the rpn stack evaluator
// joins rpn_ctrl and rpn_dpath; payload types from rpn_pkg
`timescale 1ns / 1ps

// Evaluates reverse-Polish expressions on a signed Q16.16 operand stack of
// STACK_DEPTH entries, one token per transfer. A push is written directly;
// arithmetic tokens pop two operands and then execute, multiply adds truncate
// and saturate steps, and divide waits on the divider, which retires two
// quotient bits per cycle over 48 bits; the last token adds a final pop and
// the loading of the result register. Stack reads are registered. A finished
// result waits in its output register while the next token is taken; a new
// result is held back only while the previous one has not yet been
// transferred. Results on overflow saturate; an error gives answer 0 with its
// status and the rest of the expression is dropped silently.

module rpn_stack_evaluator #(
  parameter int STACK_DEPTH = rpn_pkg::DEF_STACK_DEPTH
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             token_valid,
  output logic             token_ready,
  input  rpn_pkg::token_t  token,
  output logic             result_valid,
  input  logic             result_ready,
  output rpn_pkg::result_t result
);

  rpn_pkg::cmd_t  cmd;
  rpn_pkg::stat_t stat;

  rpn_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .token_valid (token_valid),
    .token_ready (token_ready),
    .opcode      (token.opcode),
    .last_token  (token.last_token),
    .stat        (stat),
    .cmd         (cmd)
  );

  rpn_dpath #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_dpath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .push_value   (token.operand_value),
    .stat         (stat),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

endmodule

@@ sim/tb.sv @@
// testbench for rpn_stack_evaluator: directed token table, then random expressions
// checks results against a shadow operand stack or a pinned expectation; needs rpn_pkg and the rtl
`timescale 1ns / 1ps

module tb;
  import rpn_pkg::*;

  localparam int DEPTH = DEF_STACK_DEPTH;

  localparam logic [2:0] OPC_UNDEF5 = 3'd5;
  localparam logic [2:0] OPC_UNDEF6 = 3'd6;
  localparam logic [2:0] OPC_UNDEF7 = 3'd7;

  localparam logic signed [DATA_W-1:0] Q_ONE     = 32'sh0001_0000;
  localparam logic signed [DATA_W-1:0] Q_NEG_ONE = -32'sh0001_0000;

  typedef struct {
    token_t  tok;
    bit      pin;
    result_t want;
  } plan_row_t;

  logic    clk          = 1'b0;
  logic    rst          = 1'b1;
  logic    token_valid  = 1'b0;
  logic    token_ready;
  token_t  token        = '0;
  logic    result_valid;
  logic    result_ready = 1'b0;
  result_t result;

  // typed expectation that travels with the token being offered
  bit      pin_on   = 1'b0;
  result_t pin_want = '0;

  bit      quiet = 1'b0;
  int      errors = 0;
  int      sent_count = 0;

  logic signed [DATA_W-1:0] shadow_stack [DEPTH];
  int unsigned              shadow_depth = 0;
  bit                       shadow_aborted = 1'b0;
  result_t                  pending_results [$];

  plan_row_t plan [$];

  rpn_stack_evaluator u_top (
    .clk          (clk),
    .rst          (rst),
    .token_valid  (token_valid),
    .token_ready  (token_ready),
    .token        (token),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

  always #2 clk = ~clk;

  function automatic logic signed [DATA_W-1:0] saturate(longint v);
    if (v > longint'(SAT_MAX)) return SAT_MAX;
    if (v < longint'(SAT_MIN)) return SAT_MIN;
    return v[DATA_W-1:0];
  endfunction

  function automatic void shadow_push(logic signed [DATA_W-1:0] v);
    if (shadow_depth >= DEPTH) return;
    shadow_stack[shadow_depth] = v;
    shadow_depth++;
  endfunction

  function automatic logic signed [DATA_W-1:0] shadow_pop();
    if (shadow_depth == 0) return '0;
    shadow_depth--;
    return shadow_stack[shadow_depth];
  endfunction

  function automatic void eval_token(input token_t t, output bit has, output result_t r);
    logic signed [DATA_W-1:0] a, b;
    logic [1:0]               st;
    has = 1'b0;
    r = '0;
    st = STATUS_OK;
    if (shadow_aborted) begin
      if (t.last_token) begin
        shadow_depth = 0;
        shadow_aborted = 1'b0;
      end
      return;
    end
    case (t.opcode)
      OPC_PUSH: shadow_push(t.operand_value);
      OPC_ADD: begin
        b = shadow_pop();
        a = shadow_pop();
        shadow_push(saturate(longint'(a) + longint'(b)));
      end
      OPC_SUB: begin
        b = shadow_pop();
        a = shadow_pop();
        shadow_push(saturate(longint'(a) - longint'(b)));
      end
      OPC_MUL: begin
        b = shadow_pop();
        a = shadow_pop();
        shadow_push(saturate((longint'(a) * longint'(b)) / 65536));
      end
      OPC_DIV: begin
        b = shadow_pop();
        a = shadow_pop();
        if (b == 0) st = STATUS_ZERO_DIV;
        else shadow_push(saturate((longint'(a) * 65536) / longint'(b)));
      end
      default: st = STATUS_UNKNOWN;
    endcase
    if (st != STATUS_OK) begin
      has = 1'b1;
      r.answer = '0;
      r.status = st;
      if (t.last_token) shadow_depth = 0;
      else shadow_aborted = 1'b1;
    end else if (t.last_token) begin
      has = 1'b1;
      r.answer = shadow_pop();
      r.status = STATUS_OK;
      shadow_depth = 0;
      shadow_aborted = 1'b0;
    end
  endfunction

  // result check first, then the token transfer of the same edge
  always @(posedge clk) begin
    bit      has;
    result_t want;
    if (!rst) begin
      if (result_valid && result_ready) begin
        if (pending_results.size() == 0) begin
          errors++;
          $display("%0t: unexpected result, expected none, actual answer %h status %0d",
                   $time, result.answer, result.status);
        end else begin
          want = pending_results.pop_front();
          if (result.answer !== want.answer) begin
            errors++;
            $display("%0t: answer mismatch, expected %h actual %h",
                     $time, want.answer, result.answer);
          end
          if (result.status !== want.status) begin
            errors++;
            $display("%0t: status mismatch, expected %0d actual %0d",
                     $time, want.status, result.status);
          end
        end
      end
      if (token_valid && token_ready) begin
        eval_token(token, has, want);
        if (pin_on) begin
          has = 1'b1;
          want = pin_want;
        end
        if (has) pending_results.push_back(want);
      end
    end
  end

  // receiver stalls
  int unsigned ready_hold = 0;
  always @(posedge clk) begin
    int r;
    if (ready_hold != 0) begin
      ready_hold <= ready_hold - 1;
    end else if (quiet) begin
      result_ready <= 1'b1;
    end else begin
      r = $urandom_range(0, 99);
      if (r < 60) begin
        result_ready <= 1'b1;
        ready_hold <= $urandom_range(0, 4);
      end else if (r < 95) begin
        result_ready <= 1'b0;
        ready_hold <= $urandom_range(0, 3);
      end else begin
        result_ready <= 1'b0;
        ready_hold <= $urandom_range(10, 60);
      end
    end
  end

  function automatic int pick_gap();
    int r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 80);
  endfunction

  function automatic logic signed [DATA_W-1:0] pick_value();
    int r;
    logic signed [DATA_W-1:0] v;
    r = $urandom_range(0, 99);
    if (r < 30) begin
      v = DATA_W'({$urandom_range(0, 8), 16'h0000} | $urandom_range(0, 16'hffff));
      if ($urandom_range(0, 1)) v = -v;
    end else if (r < 45) begin
      v = $urandom_range(0, 32'h3ffff);
      if ($urandom_range(0, 1)) v = -v;
    end else if (r < 55) begin
      v = '0;
    end else if (r < 65) begin
      case ($urandom_range(0, 5))
        0: v = SAT_MAX;
        1: v = SAT_MIN;
        2: v = 32'sd1;
        3: v = -32'sd1;
        4: v = Q_ONE;
        default: v = Q_NEG_ONE;
      endcase
    end else begin
      v = $urandom;
    end
    return v;
  endfunction

  function automatic logic [2:0] pick_binop();
    case ($urandom_range(0, 3))
      0: return OPC_ADD;
      1: return OPC_SUB;
      2: return OPC_MUL;
      default: return OPC_DIV;
    endcase
  endfunction

  task automatic send_token(input token_t t, input bit pin, input result_t want);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      token_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    token_valid <= 1'b1;
    token <= t;
    pin_on <= pin;
    pin_want <= want;
    do @(posedge clk); while (!token_ready);
    sent_count++;
  endtask

  task automatic send_plain(input logic [2:0] opc, input logic signed [DATA_W-1:0] val,
                            input bit last);
    token_t t;
    t.opcode = opc;
    t.operand_value = val;
    t.last_token = last;
    send_token(t, 1'b0, '0);
  endtask

  // mostly well-formed expression with random operands and operators, with an occasional undefined opcode
  task automatic send_wellformed();
    int pushes_left, ops_left, d;
    logic [2:0] opc;
    ops_left = $urandom_range(0, 9) < 8 ? $urandom_range(0, 4) : $urandom_range(5, 12);
    pushes_left = ops_left + 1;
    d = 0;
    while (pushes_left + ops_left > 0) begin
      if (d >= 2 && ops_left > 0 && (pushes_left == 0 || $urandom_range(0, 1))) begin
        opc = pick_binop();
        ops_left--;
        d--;
      end else begin
        opc = OPC_PUSH;
        pushes_left--;
        d++;
      end
      if ($urandom_range(0, 99) < 3) opc = 3'($urandom_range(OPC_UNDEF5, OPC_UNDEF7));
      send_plain(opc, pick_value(), pushes_left + ops_left == 0);
    end
  endtask

  // push up to around the stack limit, sometimes past it, then fold up to three entries
  task automatic send_fill();
    int n, k;
    n = $urandom_range(DEPTH - 4, DEPTH + 6);
    k = $urandom_range(0, 3);
    for (int i = 0; i < n; i++) send_plain(OPC_PUSH, pick_value(), k == 0 && i == n - 1);
    for (int i = 0; i < k; i++) send_plain(pick_binop(), pick_value(), i == k - 1);
  endtask

  task automatic send_noise();
    int n;
    n = $urandom_range(1, 8);
    for (int i = 0; i < n; i++)
      send_plain(3'($urandom_range(0, 7)), pick_value(),
                 i == n - 1 ? 1'b1 : 1'($urandom_range(0, 1)));
  endtask

  function automatic plan_row_t mk(logic [2:0] opc, logic signed [DATA_W-1:0] val, bit last,
                                   bit pin, logic signed [DATA_W-1:0] ans, logic [1:0] st);
    plan_row_t row;
    row.tok.opcode = opc;
    row.tok.operand_value = val;
    row.tok.last_token = last;
    row.pin = pin;
    row.want.answer = ans;
    row.want.status = st;
    return row;
  endfunction

  initial begin
    int r;
    // empty stack pops
    plan.push_back(mk(OPC_ADD, 0, 1, 1, 0, STATUS_OK));
    // add and subtract saturation
    plan.push_back(mk(OPC_PUSH, SAT_MAX, 0, 0, 0, STATUS_OK));
    plan.push_back(mk(OPC_PUSH, Q_ONE, 0, 0, 0, STATUS_OK));
    plan.push_back(mk(OPC_ADD, SAT_MIN, 1, 1, SAT_MAX, STATUS_OK));
    plan.push_back(mk(OPC_PUSH, SAT_MIN, 0, 0, 0, STATUS_OK));
    plan.push_back(mk(OPC_PUSH, Q_ONE, 0, 0, 0, STATUS_OK));
    plan.push_back(mk(OPC_SUB, SAT_MAX, 1, 1, SAT_MIN, STATUS_OK));
    // fractional multiply
    plan.push_back(mk(OPC_PUSH, 32'sh0002_8000, 0, 0, 0, STATUS_OK));
    plan.push_back(mk(OPC_PUSH, -32'sh0001_8000, 0, 0, 0, STATUS_OK));
    plan.push_back(mk(OPC_MUL, -1, 1, 0, 0, STATUS_OK));
    // zero divisor, then the rest of the expression is dropped
    plan.push_back(mk(OPC_PUSH, Q_ONE, 0, 0, 0, STATUS_OK));
    plan.push_back(mk(OPC_PUSH, 0, 0, 0, 0, STATUS_OK));
    plan.push_back(mk(OPC_DIV, 0, 0, 1, 0, STATUS_ZERO_DIV));
    plan.push_back(mk(OPC_PUSH, 32'sh0007_0000, 0, 0, 0, STATUS_OK));
    plan.push_back(mk(OPC_ADD, 0, 1, 0, 0, STATUS_OK));
    // unknown command on the last token
    plan.push_back(mk(OPC_UNDEF5, 32'sh5a5a_a5a5, 1, 1, 0, STATUS_UNKNOWN));
    // unknown command mid expression
    plan.push_back(mk(OPC_UNDEF7, 0, 0, 1, 0, STATUS_UNKNOWN));
    plan.push_back(mk(OPC_UNDEF6, SAT_MAX, 1, 0, 0, STATUS_OK));
    // divide overflow
    plan.push_back(mk(OPC_PUSH, SAT_MIN, 0, 0, 0, STATUS_OK));
    plan.push_back(mk(OPC_PUSH, Q_NEG_ONE, 0, 0, 0, STATUS_OK));
    plan.push_back(mk(OPC_DIV, 0, 1, 1, SAT_MAX, STATUS_OK));
    // multiply overflow
    plan.push_back(mk(OPC_PUSH, SAT_MAX, 0, 0, 0, STATUS_OK));
    plan.push_back(mk(OPC_PUSH, SAT_MAX, 0, 0, 0, STATUS_OK));
    plan.push_back(mk(OPC_MUL, 0, 1, 1, SAT_MAX, STATUS_OK));

    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (plan[i]) send_token(plan[i].tok, plan[i].pin, plan[i].want);

    while (sent_count < 950 + plan.size()) begin
      quiet = ($urandom_range(0, 9) == 0);
      r = $urandom_range(0, 99);
      if (r < 72) send_wellformed();
      else if (r < 76) send_fill();
      else send_noise();
    end
    quiet = 1'b0;
    token_valid <= 1'b0;
    pin_on <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (64) @(posedge clk);
    if (errors == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end

  initial begin
    #4_000_000;
    $display("simulation failed");
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/core/rpn_pkg.sv
rtl/core/rpn_div.sv
rtl/core/rpn_dpath.sv
rtl/core/rpn_ctrl.sv
rtl/core/rpn_stack_evaluator.sv
sim/tb.sv
